>>> hdl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and register codes of the pressure and temperature
// compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W      = 20;
    localparam int CFG_DATA_W = 64;
    localparam int DIV_BITS   = 64;
    localparam int OBUF_DEPTH = 2;
    localparam int PTR_W      = (OBUF_DEPTH > 1) ? $clog2(OBUF_DEPTH) : 1;
    localparam int CNT_W      = $clog2(OBUF_DEPTH + 1);

    localparam logic [32:0] PRESS_OFFSET = 33'd128000;
    localparam logic [20:0] RAW_FULL     = 21'd1048576;
    localparam logic [11:0] DIV_SCALE    = 12'd3125;
    localparam logic [31:0] ROUND_HALF   = 32'd128;
    localparam logic [63:0] V1_BIAS      = 64'd1 << 47;

    typedef enum logic [1:0] {
        CFG_TEMP_CAL   = 2'd0,
        CFG_PRESS_LOW  = 2'd1,
        CFG_PRESS_HIGH = 2'd2,
        CFG_PRESS_LAST = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } cal_t;

    // temperature side to pressure side
    typedef struct packed {
        logic               vld;
        logic signed [31:0] tc;
        logic signed [32:0] av;
        logic        [20:0] p0;
    } tp_t;

    // operands of the divider
    typedef struct packed {
        logic               vld;
        logic signed [31:0] tc;
        logic               zero;
        logic               neg;
        logic        [63:0] ma;
        logic        [63:0] mb;
    } dq_t;

    // divider result
    typedef struct packed {
        logic               vld;
        logic signed [31:0] tc;
        logic               zero;
        logic               neg;
        logic        [63:0] quo;
    } qo_t;

    typedef struct packed {
        logic signed [31:0] tc;
        logic        [31:0] pq;
        logic               zero;
    } res_t;

endpackage

>>> hdl/ptc_in_if.sv
// ----------------------------------------------------------------------------
// ptc_in_if
// Raw sample channel: one pressure and one temperature reading per beat.
// ----------------------------------------------------------------------------
interface ptc_in_if;
    import ptc_pkg::*;

    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

>>> hdl/ptc_out_if.sv
// ----------------------------------------------------------------------------
// ptc_out_if
// Compensated result channel: temperature, pressure and divisor flag.
// ----------------------------------------------------------------------------
interface ptc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic        [31:0] pressure_q8;
    logic               divisor_zero;

    modport source (output valid, output temperature_centi, output pressure_q8,
                    output divisor_zero, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_q8,
                    input divisor_zero, output ready);
endinterface

>>> hdl/ptc_temp.sv
// ----------------------------------------------------------------------------
// ptc_temp
// Five-stage temperature datapath in 32-bit wrapping arithmetic; also forms
// the centered temperature term and the inverted raw pressure.
// ----------------------------------------------------------------------------
module ptc_temp (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic                     in_vld,
    input  logic [19:0]              raw_pressure,
    input  logic [19:0]              raw_temperature,
    input  ptc_pkg::cal_t            cal,
    output ptc_pkg::tp_t             tp
);
    import ptc_pkg::*;

    logic [4:0]         vld_reg;
    logic [20:0]        p0_reg [5];
    logic [17:0]        x_reg, x_next;
    logic [16:0]        d_reg, d_next;
    logic [31:0]        m1_reg, m1_next;
    logic [31:0]        dd_reg, dd_next;
    logic [31:0]        a_reg, a_next;
    logic [31:0]        e_reg, e_next;
    logic [31:0]        fine_reg, fine_next;
    logic signed [31:0] tc_reg, tc_next;
    logic signed [32:0] av_reg, av_next;
    logic signed [33:0] mx, dsq;
    logic signed [47:0] ev;
    logic [31:0]        f5;
    logic [20:0]        p0_next;

    always_comb
    begin
        x_next    = {1'b0, raw_temperature[19:3]} - {1'b0, cal.t1, 1'b0};
        d_next    = {1'b0, raw_temperature[19:4]} - {1'b0, cal.t1};
        p0_next   = RAW_FULL - {1'b0, raw_pressure};
        mx        = $signed(x_reg) * cal.t2;
        m1_next   = mx[31:0];
        dsq       = $signed(d_reg) * $signed(d_reg);
        dd_next   = dsq[31:0];
        a_next    = 32'($signed(m1_reg) >>> 11);
        ev        = ($signed(dd_reg) >>> 12) * cal.t3;
        e_next    = ev[31:0];
        fine_next = a_reg + 32'($signed(e_reg) >>> 14);
        // fine * 5 + 128, then divide by 256
        f5        = {fine_reg[29:0], 2'b00} + fine_reg + ROUND_HALF;
        tc_next   = $signed(f5) >>> 8;
        av_next   = 33'($signed(fine_reg)) - $signed(PRESS_OFFSET);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg     <= x_next;
            d_reg     <= d_next;
            p0_reg[0] <= p0_next;
            m1_reg    <= m1_next;
            dd_reg    <= dd_next;
            p0_reg[1] <= p0_reg[0];
            a_reg     <= a_next;
            e_reg     <= e_next;
            p0_reg[2] <= p0_reg[1];
            fine_reg  <= fine_next;
            p0_reg[3] <= p0_reg[2];
            tc_reg    <= tc_next;
            av_reg    <= av_next;
            p0_reg[4] <= p0_reg[3];
        end
    end

    assign tp.vld = vld_reg[4];
    assign tp.tc  = tc_reg;
    assign tp.av  = av_reg;
    assign tp.p0  = p0_reg[4];

endmodule

>>> hdl/ptc_press.sv
// ----------------------------------------------------------------------------
// ptc_press
// Six-stage 64-bit pressure front end: builds the dividend and divisor and
// splits them into sign and magnitude for the divider.
// ----------------------------------------------------------------------------
module ptc_press (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  ptc_pkg::tp_t  tp,
    input  ptc_pkg::cal_t cal,
    output ptc_pkg::dq_t  dq
);
    import ptc_pkg::*;

    logic [5:0]         vld_reg;
    logic signed [31:0] tc_reg [6];
    logic [20:0]        p0_reg [3];
    logic [62:0]        sq_reg, sq_next;
    logic signed [48:0] a5_reg, a5_next;
    logic signed [48:0] a2_reg, a2_next;
    logic [63:0]        s6_reg, s6_next;
    logic [63:0]        s3_reg, s3_next;
    logic [63:0]        v2a_reg, v2a_next;
    logic signed [48:0] a2b_reg;
    logic [63:0]        v2_reg, v2_next;
    logic [63:0]        t_reg, t_next;
    logic [63:0]        w_reg, w_next;
    logic [63:0]        d0_reg, d0_next;
    logic [63:0]        u_reg, u_next;
    logic [63:0]        dv_reg, dv_next;
    logic               neg_reg, zero_reg;
    logic [63:0]        ma_reg, mb_reg;
    logic signed [65:0] sq_full;
    logic signed [79:0] s6_full, s3_full;

    always_comb
    begin
        sq_full  = tp.av * tp.av;
        sq_next  = sq_full[62:0];
        a5_next  = tp.av * cal.p5;
        a2_next  = tp.av * cal.p2;
        s6_full  = $signed({1'b0, sq_reg}) * cal.p6;
        s6_next  = s6_full[63:0];
        s3_full  = $signed({1'b0, sq_reg}) * cal.p3;
        s3_next  = s3_full[63:0];
        v2a_next = (64'(a5_reg) << 17) + (64'(cal.p4) << 35);
        v2_next  = s6_reg + v2a_reg;
        t_next   = 64'($signed(s3_reg) >>> 8) + (64'(a2b_reg) << 12);
        w_next   = (t_reg + V1_BIAS) * 64'(cal.p1);
        d0_next  = (64'(p0_reg[2]) << 31) - v2_reg;
        u_next   = 64'($signed(w_reg) >>> 33);
        dv_next  = d0_reg * 64'(DIV_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[4:0], tp.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tc_reg[0] <= tp.tc;
            for (int k = 1; k < 6; k++)
            begin
                tc_reg[k] <= tc_reg[k-1];
            end
            p0_reg[0] <= tp.p0;
            for (int k = 1; k < 3; k++)
            begin
                p0_reg[k] <= p0_reg[k-1];
            end
            sq_reg   <= sq_next;
            a5_reg   <= a5_next;
            a2_reg   <= a2_next;
            s6_reg   <= s6_next;
            s3_reg   <= s3_next;
            v2a_reg  <= v2a_next;
            a2b_reg  <= a2_reg;
            v2_reg   <= v2_next;
            t_reg    <= t_next;
            w_reg    <= w_next;
            d0_reg   <= d0_next;
            u_reg    <= u_next;
            dv_reg   <= dv_next;
            neg_reg  <= dv_reg[63] ^ u_reg[63];
            zero_reg <= (u_reg == '0);
            ma_reg   <= dv_reg[63] ? 64'd0 - dv_reg : dv_reg;
            mb_reg   <= u_reg[63] ? 64'd0 - u_reg : u_reg;
        end
    end

    assign dq.vld  = vld_reg[5];
    assign dq.tc   = tc_reg[5];
    assign dq.zero = zero_reg;
    assign dq.neg  = neg_reg;
    assign dq.ma   = ma_reg;
    assign dq.mb   = mb_reg;

endmodule

>>> hdl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider on 64-bit magnitudes, one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module ptc_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         advance,
    input  ptc_pkg::dq_t dq,
    output ptc_pkg::qo_t qo
);
    import ptc_pkg::*;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] dq;
    } dv_t;

    logic [DIV_BITS-1:0] vld_reg;
    dv_t                 st_reg   [DIV_BITS];
    logic [63:0]         mb_reg   [DIV_BITS];
    logic signed [31:0]  tc_reg   [DIV_BITS];
    logic                neg_reg  [DIV_BITS];
    logic                zero_reg [DIV_BITS];
    dv_t                 st_in;

    // shift in the next dividend bit, subtract the divisor where it fits
    function automatic dv_t div_step(dv_t cur, logic [63:0] mb);
        logic [64:0] sh;
        logic        ge;
        dv_t         nxt;
        sh      = {cur.rem, cur.dq[63]};
        ge      = (sh >= {1'b0, mb});
        nxt.rem = ge ? 64'(sh - {1'b0, mb}) : sh[63:0];
        nxt.dq  = {cur.dq[62:0], ge};
        return nxt;
    endfunction

    assign st_in.rem = '0;
    assign st_in.dq  = dq.ma;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[DIV_BITS-2:0], dq.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            st_reg[0]   <= div_step(st_in, dq.mb);
            mb_reg[0]   <= dq.mb;
            tc_reg[0]   <= dq.tc;
            neg_reg[0]  <= dq.neg;
            zero_reg[0] <= dq.zero;
            for (int k = 1; k < DIV_BITS; k++)
            begin
                st_reg[k]   <= div_step(st_reg[k-1], mb_reg[k-1]);
                mb_reg[k]   <= mb_reg[k-1];
                tc_reg[k]   <= tc_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end
    end

    assign qo.vld  = vld_reg[DIV_BITS-1];
    assign qo.tc   = tc_reg[DIV_BITS-1];
    assign qo.zero = zero_reg[DIV_BITS-1];
    assign qo.neg  = neg_reg[DIV_BITS-1];
    assign qo.quo  = st_reg[DIV_BITS-1].dq;

endmodule

>>> hdl/ptc_post.sv
// ----------------------------------------------------------------------------
// ptc_post
// Six-stage pressure back end: quotient sign, second-order correction and
// final offset, giving pascal times 256.
// ----------------------------------------------------------------------------
module ptc_post (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  ptc_pkg::qo_t  qo,
    input  ptc_pkg::cal_t cal,
    output logic          res_vld,
    output ptc_pkg::res_t res
);
    import ptc_pkg::*;

    logic [5:0]         vld_reg;
    logic signed [31:0] tc_reg   [6];
    logic               zero_reg [6];
    logic [63:0]        q_reg    [4];
    logic [63:0]        q_next;
    logic [63:0]        s_reg, s_next;
    logic [63:0]        x1_reg, x1_next;
    logic [63:0]        r8_reg, r8_next;
    logic [63:0]        pll_reg, pll_next;
    logic [31:0]        plh_reg, plh_next;
    logic [31:0]        phl_reg, phl_next;
    logic [63:0]        v2b_reg, v2b_next;
    logic [63:0]        v1b_reg, v1b_next;
    logic [63:0]        sum_reg, sum_next;
    logic [31:0]        pq_reg, pq_next;
    logic [63:0]        xs;

    always_comb
    begin
        q_next   = qo.neg ? 64'd0 - qo.quo : qo.quo;
        s_next   = 64'($signed(q_reg[0]) >>> 13);
        x1_next  = $signed(s_next) * cal.p9;
        // one stage later so the p8 term lines up with the p9 term
        r8_next  = $signed(q_reg[1]) * cal.p8;
        // 64 x 64 low product from three 32 x 32 pieces
        pll_next = 64'(x1_reg[31:0]) * 64'(s_reg[31:0]);
        plh_next = x1_reg[31:0] * s_reg[63:32];
        phl_next = x1_reg[63:32] * s_reg[31:0];
        v2b_next = 64'($signed(r8_reg) >>> 19);
        xs       = pll_reg + {plh_reg + phl_reg, 32'd0};
        v1b_next = 64'($signed(xs) >>> 25);
        sum_next = q_reg[3] + v1b_reg + v2b_reg;
        pq_next  = zero_reg[4] ? '0 : sum_reg[39:8] + (32'(cal.p7) << 4);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= {vld_reg[4:0], qo.vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tc_reg[0]   <= qo.tc;
            zero_reg[0] <= qo.zero;
            for (int k = 1; k < 6; k++)
            begin
                tc_reg[k]   <= tc_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
            q_reg[0] <= q_next;
            for (int k = 1; k < 4; k++)
            begin
                q_reg[k] <= q_reg[k-1];
            end
            s_reg   <= s_next;
            x1_reg  <= x1_next;
            r8_reg  <= r8_next;
            pll_reg <= pll_next;
            plh_reg <= plh_next;
            phl_reg <= phl_next;
            v2b_reg <= v2b_next;
            v1b_reg <= v1b_next;
            sum_reg <= sum_next;
            pq_reg  <= pq_next;
        end
    end

    assign res_vld  = vld_reg[5];
    assign res.tc   = tc_reg[5];
    assign res.pq   = pq_reg;
    assign res.zero = zero_reg[5];

endmodule

>>> hdl/ptc_obuf.sv
// ----------------------------------------------------------------------------
// ptc_obuf
// Small output queue between the pipeline and the result channel; its fill
// level decides when the pipeline moves.
// ----------------------------------------------------------------------------
module ptc_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ptc_pkg::res_t din,
    output logic          room,
    ptc_out_if.source     result
);
    import ptc_pkg::*;

    res_t             data_reg [OBUF_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign pop = result.valid & result.ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(OBUF_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(OBUF_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= din;
        end
    end

    assign room                     = (cnt_reg != CNT_W'(OBUF_DEPTH));
    assign result.valid             = (cnt_reg != '0);
    assign result.temperature_centi = data_reg[rd_ptr_reg].tc;
    assign result.pressure_q8       = data_reg[rd_ptr_reg].pq;
    assign result.divisor_zero      = data_reg[rd_ptr_reg].zero;

endmodule

>>> hdl/pressure_temperature_compensation.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Integer compensation of raw barometric pressure and temperature readings.
//
// sample: one beat carries raw_pressure and raw_temperature (20 bits each)
// result: one beat per sample with temperature_centi (0.01 C), pressure_q8
//         (Pa * 256, low 32 bits) and divisor_zero (pressure forced to 0)
// cfg_we / cfg_index / cfg_data: write port for the four calibration
//         registers; write them only while no sample is in flight
// Throughput: one sample per cycle while the output queue has room.
// Path: a sample passes through 5 temperature stages, 6 pressure stages,
//   64 divider stages (one quotient bit each), 6 correction stages and
//   then the output queue.
// Stall: the whole pipeline moves together and is held only while the
//   two-entry output queue is full, so sample.ready is decoded from the
//   registered queue count and nothing is lost or repeated.
// Reset: calibration registers clear to zero, all stages and the queue go
//   empty; with zero calibration every result has divisor_zero set.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
    input  logic                               clk,
    input  logic                               rst_n,
    ptc_in_if.sink                             sample,
    ptc_out_if.source                          result,
    input  logic                               cfg_we,
    input  ptc_pkg::cfg_idx_t                  cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ptc_pkg::*;

    logic [47:0] temp_cal_reg;
    logic [63:0] press_cal_low_reg;
    logic [63:0] press_cal_high_reg;
    logic [15:0] press_cal_last_reg;
    cal_t        cal;
    logic        advance;
    tp_t         tp;
    dq_t         dq;
    qo_t         qo;
    logic        res_vld;
    res_t        res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg       <= '0;
            press_cal_low_reg  <= '0;
            press_cal_high_reg <= '0;
            press_cal_last_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TEMP_CAL:   temp_cal_reg       <= cfg_data[47:0];
                CFG_PRESS_LOW:  press_cal_low_reg  <= cfg_data;
                CFG_PRESS_HIGH: press_cal_high_reg <= cfg_data;
                CFG_PRESS_LAST: press_cal_last_reg <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    assign cal.t1 = temp_cal_reg[15:0];
    assign cal.t2 = $signed(temp_cal_reg[31:16]);
    assign cal.t3 = $signed(temp_cal_reg[47:32]);
    assign cal.p1 = press_cal_low_reg[15:0];
    assign cal.p2 = $signed(press_cal_low_reg[31:16]);
    assign cal.p3 = $signed(press_cal_low_reg[47:32]);
    assign cal.p4 = $signed(press_cal_low_reg[63:48]);
    assign cal.p5 = $signed(press_cal_high_reg[15:0]);
    assign cal.p6 = $signed(press_cal_high_reg[31:16]);
    assign cal.p7 = $signed(press_cal_high_reg[47:32]);
    assign cal.p8 = $signed(press_cal_high_reg[63:48]);
    assign cal.p9 = $signed(press_cal_last_reg);

    assign sample.ready = advance;

    ptc_temp u_temp (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .in_vld          (sample.valid),
        .raw_pressure    (sample.raw_pressure),
        .raw_temperature (sample.raw_temperature),
        .cal             (cal),
        .tp              (tp)
    );

    ptc_press u_press (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .tp      (tp),
        .cal     (cal),
        .dq      (dq)
    );

    ptc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .dq      (dq),
        .qo      (qo)
    );

    ptc_post u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .qo      (qo),
        .cal     (cal),
        .res_vld (res_vld),
        .res     (res)
    );

    ptc_obuf u_obuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (advance & res_vld),
        .din    (res),
        .room   (advance),
        .result (result)
    );

    // a flagged divisor always comes with zero pressure
    a_zero_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.divisor_zero) |-> (result.pressure_q8 == '0))
        else $error("divisor flag with nonzero pressure");

    // the pipeline only stalls with a result waiting at the output
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> result.valid)
        else $error("input stalled with empty output");

    // a full queue stays full until a result beat leaves
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!sample.ready && !(result.valid && result.ready)) |=> !sample.ready)
        else $error("stall released without an output beat");

endmodule
